[sv/dq_pkg.sv]
// Shared types and constants for the double-ended queue.
// No dependencies; used by every other file of the block.
package dq_pkg;

  localparam int DefaultDepth = 16;
  localparam int DataWidth    = 32;
  localparam int OpWidth      = 3;
  localparam int CountWidth   = 5;
  localparam int ErrWidth     = 2;

  typedef logic signed [DataWidth-1:0] data_t;

  typedef enum logic [OpWidth-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_PEEK       = 3'd4
  } op_t;

  typedef enum logic [ErrWidth-1:0] {
    ERR_NONE  = 2'd0,
    ERR_EMPTY = 2'd1,
    ERR_FULL  = 2'd2
  } err_t;

  typedef struct packed {
    logic [OpWidth-1:0] op;
    data_t              push_value;
  } req_t;

  typedef struct packed {
    data_t                 front_value;
    data_t                 rear_value;
    logic [CountWidth-1:0] element_count;
    logic                  is_empty;
    logic [ErrWidth-1:0]   error_code;
  } rsp_t;

  // Broadcast to every cell; at most one bit set, only for a legal operation.
  typedef struct packed {
    logic push_front;
    logic push_back;
    logic pop_front;
    logic pop_back;
  } dq_cmd_t;

  // One slot of the chain: occupancy plus the element in front order (f)
  // and the element in rear order (r).
  typedef struct packed {
    logic  valid;
    data_t f;
    data_t r;
  } dq_cell_t;

endpackage

[sv/double_ended_queue.sv]
// Double-ended queue of 32-bit signed values, DEPTH slots. Each request does push
// front, push back, pop front, pop back or peek and returns one response with front
// and rear values, count (low 5 bits), empty flag and error code. The store is a
// row of DEPTH cells kept twice, once in front order and once in rear order, so
// both ends sit in cell 0 and every cell updates from its neighbors. A request is
// taken every cycle unless the input stalls, and its response is registered and
// shows in the cycle after acceptance unless an earlier response is still waiting.
// A two-entry output stage lets one more request in while a response waits; the
// input then stalls until the waiting response leaves. Depends on dq_pkg and dq_cell.
module double_ended_queue #(
  parameter int DEPTH = dq_pkg::DefaultDepth
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         req_valid,
  output logic         req_ready,
  input  dq_pkg::req_t req,
  output logic         rsp_valid,
  input  logic         rsp_ready,
  output dq_pkg::rsp_t rsp
);

  localparam int CW = $clog2(DEPTH + 1);

  dq_pkg::dq_cell_t state      [DEPTH];
  dq_pkg::dq_cell_t state_next [DEPTH];
  dq_pkg::dq_cmd_t  cmd;
  dq_pkg::err_t     err;
  dq_pkg::rsp_t     result;
  dq_pkg::rsp_t     skid;

  logic [CW-1:0]                       count;
  logic [CW-1:0]                       count_next;
  logic [CW+dq_pkg::CountWidth-1:0]    count_ext;
  logic                                full;
  logic                                empty;
  logic                                accept;
  logic                                rsp_fire;
  logic                                skid_valid;

  assign accept   = req_valid && req_ready;
  assign rsp_fire = rsp_valid && rsp_ready;
  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);

  // request decode
  always_comb begin
    cmd = '0;
    err = dq_pkg::ERR_NONE;
    unique case (dq_pkg::op_t'(req.op))
      dq_pkg::OP_PUSH_FRONT: begin
        if (full) err = dq_pkg::ERR_FULL;
        else      cmd.push_front = accept;
      end
      dq_pkg::OP_PUSH_BACK: begin
        if (full) err = dq_pkg::ERR_FULL;
        else      cmd.push_back = accept;
      end
      dq_pkg::OP_POP_FRONT: begin
        if (empty) err = dq_pkg::ERR_EMPTY;
        else       cmd.pop_front = accept;
      end
      dq_pkg::OP_POP_BACK: begin
        if (empty) err = dq_pkg::ERR_EMPTY;
        else       cmd.pop_back = accept;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    count_next = count;
    if (cmd.push_front || cmd.push_back) begin
      count_next = count + CW'(1);
    end else if (cmd.pop_front || cmd.pop_back) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // cell chain; cell 0 sees the new value on its open side
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    dq_pkg::dq_cell_t left;
    dq_pkg::dq_cell_t right;
    if (i == 0) begin : g_head
      assign left = '{valid: 1'b1, f: req.push_value, r: req.push_value};
    end else begin : g_mid
      assign left = state[i-1];
    end
    if (i == DEPTH - 1) begin : g_end
      assign right = '{valid: 1'b0, f: '0, r: '0};
    end else begin : g_body
      assign right = state[i+1];
    end
    dq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .push_value(req.push_value),
      .left      (left),
      .right     (right),
      .state     (state[i]),
      .state_next(state_next[i])
    );
  end

  assign count_ext = {{dq_pkg::CountWidth{1'b0}}, count_next};

  always_comb begin
    result.front_value   = state_next[0].valid ? state_next[0].f : '0;
    result.rear_value    = state_next[0].valid ? state_next[0].r : '0;
    result.element_count = count_ext[dq_pkg::CountWidth-1:0];
    result.is_empty      = (count_next == '0);
    result.error_code    = err;
  end

  // output register with one skid entry
  assign req_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (rsp_fire) begin
        skid_valid <= 1'b0;
      end
    end else if (accept) begin
      if (rsp_valid && !rsp_ready) begin
        skid_valid <= 1'b1;
      end else begin
        rsp_valid <= 1'b1;
      end
    end else if (rsp_fire) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (rsp_fire) begin
        rsp <= skid;
      end
    end else if (accept) begin
      if (rsp_valid && !rsp_ready) begin
        skid <= result;
      end else begin
        rsp <= result;
      end
    end
  end

endmodule

[sv/dq_cell.sv]
// One slot of the deque chain: holds an element of the front-ordered row,
// an element of the rear-ordered row and an occupancy bit. Uses dq_pkg.
module dq_cell (
  input  logic              clk,
  input  logic              rst,
  input  dq_pkg::dq_cmd_t   cmd,
  input  dq_pkg::data_t     push_value,
  input  dq_pkg::dq_cell_t  left,
  input  dq_pkg::dq_cell_t  right,
  output dq_pkg::dq_cell_t  state,
  output dq_pkg::dq_cell_t  state_next
);

  logic first_free;
  assign first_free = !state.valid && left.valid;

  always_comb begin
    state_next = state;
    if (cmd.push_front) begin
      state_next.valid = state.valid | left.valid;
      state_next.f     = left.f;
      if (first_free) begin
        state_next.r = push_value;
      end
    end else if (cmd.push_back) begin
      state_next.valid = state.valid | left.valid;
      state_next.r     = left.r;
      if (first_free) begin
        state_next.f = push_value;
      end
    end else if (cmd.pop_front) begin
      // rear row loses its last entry through the occupancy bit alone
      state_next.valid = state.valid & right.valid;
      state_next.f     = right.f;
    end else if (cmd.pop_back) begin
      state_next.valid = state.valid & right.valid;
      state_next.r     = right.r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.valid <= 1'b0;
    end else begin
      state.valid <= state_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    state.f <= state_next.f;
    state.r <= state_next.r;
  end

endmodule

[sv/dq_checker.sv]
// Port-level checks for double_ended_queue, attached by bind.
// Depends on dq_pkg.
module dq_checker (
  input logic         clk,
  input logic         rst,
  input logic         req_valid,
  input logic         req_ready,
  input logic         rsp_valid,
  input logic         rsp_ready,
  input dq_pkg::rsp_t rsp
);

  // a waiting response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  // every taken request leaves a response pending
  a_req_rsp: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> rsp_valid)
    else $error("request taken without a response");

  // empty queue shows zero at both ends
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.is_empty |-> rsp.front_value == '0 && rsp.rear_value == '0)
    else $error("empty queue with nonzero end value");

  // failed pop leaves the queue empty
  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.error_code == dq_pkg::ERR_EMPTY |-> rsp.is_empty)
    else $error("pop error on non-empty queue");

  // failed push leaves the queue non-empty
  a_push_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.error_code == dq_pkg::ERR_FULL |-> !rsp.is_empty)
    else $error("push error on empty queue");

endmodule

bind double_ended_queue dq_checker u_dq_checker (.*);

[test/tb_double_ended_queue.sv]
`timescale 1ns / 100ps
// Testbench for double_ended_queue: random and directed deque requests checked
// against a shadow deque in a scoreboard class. Depends on dq_pkg and the RTL.
module tb_double_ended_queue;

  localparam int QueueDepth     = dq_pkg::DefaultDepth;
  localparam int OpBits         = dq_pkg::OpWidth;
  localparam int DataBits       = dq_pkg::DataWidth;
  localparam int CountBits      = dq_pkg::CountWidth;
  localparam int ClkPeriod      = 8;
  localparam int ResetCycles    = 8;
  localparam int RandomRequests = 1200;
  localparam int HoldOffCycles  = 300;
  localparam int HoldOffAfter   = 400;
  localparam int DrainCycles    = 10;
  localparam int CycleLimit     = 200000;

  // op codes the block treats as a plain peek
  localparam logic [OpBits-1:0] OpUnusedLo  = 3'd5;
  localparam logic [OpBits-1:0] OpUnusedMid = 3'd6;
  localparam logic [OpBits-1:0] OpUnusedHi  = 3'd7;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED} op_mix_t;

  class deque_scoreboard;
    dq_pkg::data_t contents[$];
    dq_pkg::rsp_t  expected_rsps[$];
    int unsigned   errors;
    int unsigned   checked;

    function int pending();
      return expected_rsps.size();
    endfunction

    function void note_request(dq_pkg::req_t r);
      dq_pkg::rsp_t e;
      dq_pkg::err_t err;
      err = dq_pkg::ERR_NONE;
      case (r.op)
        dq_pkg::OP_PUSH_FRONT: begin
          if (contents.size() >= QueueDepth) err = dq_pkg::ERR_FULL;
          else contents.push_front(r.push_value);
        end
        dq_pkg::OP_PUSH_BACK: begin
          if (contents.size() >= QueueDepth) err = dq_pkg::ERR_FULL;
          else contents.push_back(r.push_value);
        end
        dq_pkg::OP_POP_FRONT: begin
          if (contents.size() == 0) err = dq_pkg::ERR_EMPTY;
          else void'(contents.pop_front());
        end
        dq_pkg::OP_POP_BACK: begin
          if (contents.size() == 0) err = dq_pkg::ERR_EMPTY;
          else void'(contents.pop_back());
        end
        default: ;
      endcase
      e.front_value   = (contents.size() != 0) ? contents[0] : '0;
      e.rear_value    = (contents.size() != 0) ? contents[$] : '0;
      e.element_count = CountBits'(contents.size());
      e.is_empty      = (contents.size() == 0);
      e.error_code    = err;
      expected_rsps.push_back(e);
    endfunction

    function void compare_field(string name, logic [DataBits-1:0] want,
                                logic [DataBits-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_response(dq_pkg::rsp_t a);
      dq_pkg::rsp_t e;
      if (expected_rsps.size() == 0) begin
        $error("response with no request outstanding");
        errors++;
        return;
      end
      e = expected_rsps.pop_front();
      checked++;
      compare_field("front_value", e.front_value, a.front_value);
      compare_field("rear_value", e.rear_value, a.rear_value);
      compare_field("element_count", DataBits'(e.element_count),
                    DataBits'(a.element_count));
      compare_field("is_empty", DataBits'(e.is_empty), DataBits'(a.is_empty));
      compare_field("error_code", DataBits'(e.error_code), DataBits'(a.error_code));
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst;
  logic         req_valid;
  logic         req_ready;
  dq_pkg::req_t req;
  logic         rsp_valid;
  logic         rsp_ready;
  dq_pkg::rsp_t rsp;
  int           cycles = 0;

  deque_scoreboard board;

  double_ended_queue #(.DEPTH(QueueDepth)) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // sample handshakes at the edge, before the edge's updates land
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready) board.note_request(req);
      if (rsp_valid && rsp_ready) board.check_response(rsp);
    end
  end

  function automatic dq_pkg::req_t make_req(logic [OpBits-1:0] op, dq_pkg::data_t value);
    dq_pkg::req_t r;
    r.op         = op;
    r.push_value = value;
    return r;
  endfunction

  // returns at the edge where the request is taken; valid stays high
  task automatic send_request(dq_pkg::req_t r);
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (!req_ready);
  endtask

  task automatic idle_sender(int n);
    req_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic logic [OpBits-1:0] pick_op(op_mix_t mix);
    int roll;
    int push_cut;
    roll     = $urandom_range(0, 99);
    push_cut = (mix == MIX_FILL) ? 80 : (mix == MIX_DRAIN) ? 30 : 54;
    if (roll < 3) return OpBits'($urandom_range(OpUnusedLo, OpUnusedHi));
    if (roll < 8) return dq_pkg::OP_PEEK;
    if (roll < push_cut) begin
      return $urandom_range(0, 1) ? dq_pkg::OP_PUSH_FRONT : dq_pkg::OP_PUSH_BACK;
    end
    return $urandom_range(0, 1) ? dq_pkg::OP_POP_FRONT : dq_pkg::OP_POP_BACK;
  endfunction

  function automatic dq_pkg::data_t pick_value();
    case ($urandom_range(0, 11))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return '0;
      3:       return '1;
      default: return $urandom();
    endcase
  endfunction

  task automatic run_directed();
    send_request(make_req(dq_pkg::OP_PEEK, 32'h1234_5678));
    send_request(make_req(dq_pkg::OP_POP_FRONT, '0));
    send_request(make_req(dq_pkg::OP_POP_BACK, '0));
    send_request(make_req(OpUnusedLo, '1));
    send_request(make_req(OpUnusedMid, '0));
    send_request(make_req(OpUnusedHi, 32'h8000_0000));
    send_request(make_req(dq_pkg::OP_PUSH_FRONT, 32'h7fff_ffff));
    send_request(make_req(dq_pkg::OP_PUSH_BACK, 32'h8000_0000));
    send_request(make_req(dq_pkg::OP_PEEK, '0));
    send_request(make_req(dq_pkg::OP_POP_FRONT, '0));
    send_request(make_req(dq_pkg::OP_POP_FRONT, '0));
    send_request(make_req(dq_pkg::OP_POP_BACK, '0));
    send_request(make_req(dq_pkg::OP_PUSH_BACK, '0));
    send_request(make_req(dq_pkg::OP_PUSH_FRONT, '1));
    send_request(make_req(dq_pkg::OP_PUSH_BACK, 32'h5555_5555));
    send_request(make_req(dq_pkg::OP_PUSH_FRONT, 32'haaaa_aaaa));
    send_request(make_req(OpUnusedLo, 32'h0bad_f00d));
    send_request(make_req(dq_pkg::OP_POP_BACK, '0));
    send_request(make_req(dq_pkg::OP_POP_BACK, '0));
    send_request(make_req(dq_pkg::OP_POP_FRONT, '0));
    send_request(make_req(dq_pkg::OP_POP_FRONT, '0));
    send_request(make_req(dq_pkg::OP_PEEK, '0));
  endtask

  // phases lean toward pushing or popping so the full and empty edges get hit
  task automatic run_random();
    int           burst;
    int           phase_left;
    op_mix_t      mix;
    dq_pkg::req_t r;
    burst      = 0;
    phase_left = 0;
    mix        = MIX_BALANCED;
    for (int n = 0; n < RandomRequests; n++) begin
      if (phase_left == 0) begin
        mix        = op_mix_t'($urandom_range(0, 2));
        phase_left = $urandom_range(20, 80);
      end
      phase_left--;
      if (burst == 0) begin
        idle_sender($urandom_range(1, 10));
        burst = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                            : $urandom_range(1, 20);
      end
      burst--;
      r = make_req(pick_op(mix), pick_value());
      send_request(r);
    end
  endtask

  initial begin : receiver
    int seg;
    int mode;
    bit held;
    held = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      // one long stall while requests keep coming, to back the block up
      if (!held && board.checked >= HoldOffAfter) begin
        held = 1'b1;
        rsp_ready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk);
      end
      seg  = $urandom_range(10, 60);
      mode = $urandom_range(0, 2);
      repeat (seg) begin
        case (mode)
          0:       rsp_ready <= 1'b1;
          1:       rsp_ready <= ($urandom_range(0, 3) != 0);
          default: rsp_ready <= ($urandom_range(0, 2) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    rsp_ready = 1'b0;
    board     = new();
    repeat (ResetCycles) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    run_random();
    req_valid <= 1'b0;
    do @(negedge clk); while (board.pending() != 0);
    repeat (DrainCycles) @(posedge clk);
    if (board.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[double_ended_queue.f]
sv/dq_pkg.sv
sv/dq_cell.sv
sv/double_ended_queue.sv
sv/dq_checker.sv
test/tb_double_ended_queue.sv
